@@ sv/itcf_pkg.sv @@
// Shared constants, types and one's-complement helpers for the checksum fill block.
`default_nettype none

package itcf_pkg;

   localparam int CountWidth = 17;

   localparam logic [CountWidth-1:0] COUNT_MAX   = '1;
   localparam logic [CountWidth-1:0] HDR_LEN     = 17'd20;
   localparam logic [CountWidth-1:0] CSUM_OFF_IP = 17'd10;
   localparam logic [CountWidth-1:0] CSUM_OFF_TCP = 17'd36;
   localparam logic [CountWidth-1:0] ADDR_START  = 17'd12;
   localparam logic [CountWidth:0]   MIN_LEN     = 18'd40;
   localparam logic [CountWidth:0]   MAX_LEN     = 18'd65535;
   localparam logic [15:0]           PROTO_WORD  = 16'h0006;
   localparam logic [15:0]           HDR_LEN16   = 16'd20;

   // Sums, length and error flag from the accumulator to the finishing stage at packet end.
   typedef struct packed {
      logic [15:0] header_sum;
      logic [15:0] segment_sum;
      logic [15:0] segment_length;
      logic        length_error;
   } tail_type;

   // 16-bit one's-complement add with end-around carry.
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   // A zero sum is taken as 0xffff before inversion, so the result is zero there.
   function automatic logic [15:0] finish(input logic [15:0] s);
      return (s == 16'd0) ? 16'd0 : ~s;
   endfunction

endpackage

`default_nettype wire

@@ sv/itcf_accum.sv @@
// Per-byte accumulator: byte count, header sum, segment sum and pending high byte.
`default_nettype none

module itcf_accum (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         data_byte,
   input  wire logic               last_byte,
   output itcf_pkg::tail_type      tail
);

   logic [itcf_pkg::CountWidth-1:0] byte_count_ff, byte_count_in;
   logic [15:0]                     header_sum_ff, header_sum_in;
   logic [15:0]                     segment_sum_ff, segment_sum_in;
   logic [7:0]                      pending_ff, pending_in;

   logic                            odd;
   logic                            take;
   logic [itcf_pkg::CountWidth-1:0] start;
   logic [15:0]                     word;
   logic                            hdr_hit;
   logic                            seg_hit;
   logic [15:0]                     hsum_new;
   logic [15:0]                     ssum_new;
   logic [itcf_pkg::CountWidth:0]   total;

   always_comb begin
      odd   = byte_count_ff[0];
      take  = odd || last_byte;
      start = {byte_count_ff[itcf_pkg::CountWidth-1:1], 1'b0};
      word  = odd ? {pending_ff, data_byte} : {data_byte, 8'h00};
      hdr_hit = (start < itcf_pkg::HDR_LEN) && (start != itcf_pkg::CSUM_OFF_IP);
      seg_hit = (start >= itcf_pkg::ADDR_START) && (start != itcf_pkg::CSUM_OFF_TCP);
      hsum_new = (take && hdr_hit) ? itcf_pkg::ones_add(header_sum_ff, word) : header_sum_ff;
      ssum_new = (take && seg_hit) ? itcf_pkg::ones_add(segment_sum_ff, word)
                                   : segment_sum_ff;
      total = {1'b0, byte_count_ff} + {{itcf_pkg::CountWidth{1'b0}}, 1'b1};

      tail.header_sum     = hsum_new;
      tail.segment_sum    = ssum_new;
      tail.segment_length = total[15:0] - itcf_pkg::HDR_LEN16;
      tail.length_error   = (total < itcf_pkg::MIN_LEN) || (total > itcf_pkg::MAX_LEN);
   end

   always_comb begin
      byte_count_in  = byte_count_ff;
      header_sum_in  = header_sum_ff;
      segment_sum_in = segment_sum_ff;
      pending_in     = pending_ff;
      if (step) begin
         if (last_byte) begin
            byte_count_in  = '0;
            header_sum_in  = '0;
            segment_sum_in = '0;
            pending_in     = '0;
         end else begin
            // The count sticks at its maximum so an overlong packet still ends in error.
            if (byte_count_ff != itcf_pkg::COUNT_MAX) begin
               byte_count_in = byte_count_ff + 1'b1;
            end
            header_sum_in  = hsum_new;
            segment_sum_in = ssum_new;
            if (!odd) begin
               pending_in = data_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         header_sum_ff  <= '0;
         segment_sum_ff <= '0;
         pending_ff     <= '0;
      end else begin
         byte_count_ff  <= byte_count_in;
         header_sum_ff  <= header_sum_in;
         segment_sum_ff <= segment_sum_in;
         pending_ff     <= pending_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/ipv4_tcp_checksum_fill.sv @@
// Throughput: one packet byte per cycle; a last byte stalls only while the tail stage is blocked.
// Bytes run through an input register and the per-byte sum update; a last byte's sums
// pass a tail register, gain the pseudo-header words and land in the result register.
// Synchronous reset clears the byte count, both sums and every valid flag.
`default_nettype none

module ipv4_tcp_checksum_fill (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_ip_header_checksum,
   output logic [15:0]      rsp_tcp_segment_checksum,
   output logic             rsp_length_error
);

   logic               in_valid_ff;
   logic [7:0]         in_data_ff;
   logic               in_last_ff;
   logic               fin_valid_ff;
   itcf_pkg::tail_type fin_ff;
   logic               out_valid_ff;
   logic [15:0]        out_ip_ff, out_ip_in;
   logic [15:0]        out_tcp_ff, out_tcp_in;
   logic               out_err_ff;

   logic               out_free;
   logic               fin_free;
   logic               in_go;
   logic               in_free;
   itcf_pkg::tail_type tail;
   logic [15:0]        seg_proto;
   logic [15:0]        seg_full;

   always_comb begin
      out_free  = !out_valid_ff || rsp_ready;
      fin_free  = !fin_valid_ff || out_free;
      // Only a last byte needs room further down; other bytes just update the sums.
      in_go     = in_valid_ff && (!in_last_ff || fin_free);
      in_free   = !in_valid_ff || in_go;
      req_ready = in_free;
   end

   itcf_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .step      (in_go),
      .data_byte (in_data_ff),
      .last_byte (in_last_ff),
      .tail      (tail)
   );

   always_comb begin
      seg_proto = itcf_pkg::ones_add(fin_ff.segment_sum, itcf_pkg::PROTO_WORD);
      seg_full  = itcf_pkg::ones_add(seg_proto, fin_ff.segment_length);
      if (fin_ff.length_error) begin
         out_ip_in  = 16'd0;
         out_tcp_in = 16'd0;
      end else begin
         out_ip_in  = itcf_pkg::finish(fin_ff.header_sum);
         out_tcp_in = itcf_pkg::finish(seg_full);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_free) begin
            in_valid_ff <= req_valid;
         end
         if (fin_free) begin
            fin_valid_ff <= in_go && in_last_ff;
         end
         if (out_free) begin
            out_valid_ff <= fin_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_free) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (fin_free) begin
         fin_ff <= tail;
      end
      if (out_free) begin
         out_ip_ff  <= out_ip_in;
         out_tcp_ff <= out_tcp_in;
         out_err_ff <= fin_ff.length_error;
      end
   end

   assign rsp_valid                = out_valid_ff;
   assign rsp_ip_header_checksum   = out_ip_ff;
   assign rsp_tcp_segment_checksum = out_tcp_ff;
   assign rsp_length_error         = out_err_ff;

   // A packet with a bad length reports both checksums as zero.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_error |->
         rsp_ip_header_checksum == 16'd0 && rsp_tcp_segment_checksum == 16'd0)
      else $error("length error beat carries a nonzero checksum");

   // The inverted sum of a nonzero value can never be all ones.
   a_ip_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_length_error |-> rsp_ip_header_checksum != 16'hffff)
      else $error("header checksum is all ones");

   // A last byte that moves on must land in the tail stage.
   a_last_to_tail: assert property (@(posedge clock) disable iff (reset)
      in_go && in_last_ff |=> fin_valid_ff)
      else $error("last byte lost before the tail stage");

   // The tail stage holds while the result register is blocked.
   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      fin_valid_ff && !out_free |=> fin_valid_ff && $stable(fin_ff))
      else $error("tail stage changed under a stall");

endmodule

`default_nettype wire
